FILE: rtl/sltl_pkg.sv
`default_nettype none
package sltl_pkg;

    // Lexer mode codes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_STRING = 2'd2;
    localparam logic [1:0] MODE_NUMBER = 2'd3;

    // Token kind codes.
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_NUMBER = 3'd3;
    localparam logic [2:0] KIND_SYMBOL = 3'd4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    // Most results one text byte can cause.
    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       token_end;
        logic       unterminated;
        logic       run_last;
    } sltl_res_t;

    typedef struct packed {
        logic [1:0]                  count;
        sltl_res_t [MAX_RES-1:0]     res;
        logic [1:0]                  mode;
        logic                        dot;
    } sltl_dec_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        case (c)
            "{", "}", "(", ")", "!", ";", "+", "=",
            ",", "-", "*", "&", "|", "#": is_symbol = 1'b1;
            default:                     is_symbol = 1'b0;
        endcase
    endfunction

    function automatic sltl_res_t make_res(input logic [2:0] kind,
                                           input logic [7:0] value,
                                           input logic       token_end,
                                           input logic       unterminated);
        sltl_res_t r;
        r.kind         = kind;
        r.value        = value;
        r.token_end    = token_end;
        r.unterminated = unterminated;
        r.run_last     = 1'b0;
        make_res = r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/script_token_lexer.sv
// Path: an accepted text byte waits in the input register and is decoded once the
// result buffer can take its results, which then leave from the result buffer.
// Throughput: one byte per cycle while each byte causes at most one result and
// token_ready is high; a byte with two or three results holds the input until its
// earlier results have left, as the buffer drains one per cycle with token_ready high.
// Reset: rst_n clears the mode to idle, the dot flag and both valid flags at once.
`default_nettype none
module script_token_lexer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       text_valid,
    output logic            text_ready,
    input  wire logic [7:0] text_byte,
    output logic            token_valid,
    input  wire logic       token_ready,
    output logic [2:0]      token_kind,
    output logic [7:0]      value_byte,
    output logic            token_end,
    output logic            unterminated,
    output logic            run_last
);
    import sltl_pkg::*;

    // Input register: holds one accepted byte until it is decoded.
    logic [7:0]  byte_reg;
    logic        full_reg;
    logic        full_next;

    // Lexer state.
    logic [1:0]  mode_reg;
    logic        dot_reg;

    // Result buffer: the results of one byte, drained one per cycle while token_ready is high.
    sltl_res_t   ent_reg [MAX_RES];
    logic [1:0]  rem_reg;
    logic [1:0]  rem_next;
    logic [1:0]  head_reg;
    logic [1:0]  head_next;

    sltl_dec_t   dec;
    logic        pop;
    logic        take_byte;
    sltl_res_t   cur;

    sltl_decode u_decode (
        .mode      (mode_reg),
        .dot       (dot_reg),
        .text_byte (byte_reg),
        .dec       (dec)
    );

    // A held byte is decoded once the buffer is empty or its last
    // result leaves in this same cycle.
    assign pop        = (rem_reg != 2'd0) && token_ready;
    assign take_byte  = full_reg && ((rem_reg == 2'd0) || ((rem_reg == 2'd1) && token_ready));
    assign text_ready = !full_reg || take_byte;

    always_comb
    begin
        full_next = full_reg;
        if (text_valid && text_ready)
        begin
            full_next = 1'b1;
        end
        else if (take_byte)
        begin
            full_next = 1'b0;
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        head_next = head_reg;
        if (take_byte)
        begin
            rem_next  = dec.count;
            head_next = 2'd0;
        end
        else if (pop)
        begin
            rem_next  = rem_reg - 2'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            mode_reg <= MODE_IDLE;
            dot_reg  <= 1'b0;
            rem_reg  <= 2'd0;
            head_reg <= 2'd0;
        end
        else
        begin
            full_reg <= full_next;
            rem_reg  <= rem_next;
            head_reg <= head_next;
            if (take_byte)
            begin
                mode_reg <= dec.mode;
                dot_reg  <= dec.dot;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            byte_reg <= text_byte;
        end
        if (take_byte)
        begin
            ent_reg[0] <= dec.res[0];
            ent_reg[1] <= dec.res[1];
            ent_reg[2] <= dec.res[2];
        end
    end

    assign cur          = ent_reg[head_reg];
    assign token_valid  = (rem_reg != 2'd0);
    assign token_kind   = cur.kind;
    assign value_byte   = cur.value;
    assign token_end    = cur.token_end;
    assign unterminated = cur.unterminated;
    assign run_last     = cur.run_last;

endmodule
`default_nettype wire

FILE: rtl/sltl_decode.sv
`default_nettype none
// Combinational token decoder: from the current mode and one text byte it
// produces up to three results and the next mode.
module sltl_decode (
    input  wire logic [1:0]       mode,
    input  wire logic             dot,
    input  wire logic [7:0]       text_byte,
    output sltl_pkg::sltl_dec_t   dec
);
    import sltl_pkg::*;

    logic [1:0]  idle_n;
    sltl_res_t   idle_r0;
    sltl_res_t   idle_r1;
    logic [1:0]  idle_mode;
    logic        idle_dot;
    logic [1:0]  n;
    sltl_res_t [MAX_RES-1:0] r;
    logic [1:0]  nmode;
    logic        ndot;
    logic        letter;
    logic        digit;

    assign letter = is_letter(text_byte);
    assign digit  = is_digit(text_byte);

    // What the byte does when seen in idle mode.
    always_comb
    begin
        idle_n    = 2'd0;
        idle_r0   = make_res(KIND_SYMBOL, text_byte, 1'b0, 1'b0);
        idle_r1   = make_res(KIND_SYMBOL, CHAR_NUL, 1'b1, 1'b0);
        idle_mode = MODE_IDLE;
        idle_dot  = dot;
        if (letter)
        begin
            idle_n    = 2'd1;
            idle_r0   = make_res(KIND_IDENT, text_byte, 1'b0, 1'b0);
            idle_mode = MODE_IDENT;
        end
        else if (text_byte == CHAR_QUOTE)
        begin
            idle_mode = MODE_STRING;
        end
        else if (digit)
        begin
            idle_n    = 2'd1;
            idle_r0   = make_res(KIND_NUMBER, text_byte, 1'b0, 1'b0);
            idle_mode = MODE_NUMBER;
            idle_dot  = 1'b0;
        end
        else if (is_symbol(text_byte))
        begin
            idle_n = 2'd2;
        end
    end

    always_comb
    begin
        n     = idle_n;
        r[0]  = idle_r0;
        r[1]  = idle_r1;
        r[2]  = idle_r1;
        nmode = idle_mode;
        ndot  = idle_dot;
        case (mode)
            MODE_IDENT:
            begin
                if (letter || digit || (text_byte == CHAR_DOT))
                begin
                    n     = 2'd1;
                    r[0]  = make_res(KIND_IDENT, text_byte, 1'b0, 1'b0);
                    nmode = MODE_IDENT;
                    ndot  = dot;
                end
                else
                begin
                    // End marker, then the byte again as in idle mode.
                    n    = idle_n + 2'd1;
                    r[0] = make_res(KIND_IDENT, CHAR_NUL, 1'b1, 1'b0);
                    r[1] = idle_r0;
                    r[2] = idle_r1;
                end
            end
            MODE_STRING:
            begin
                n    = 2'd1;
                ndot = dot;
                if (text_byte == CHAR_QUOTE)
                begin
                    r[0]  = make_res(KIND_STRING, CHAR_NUL, 1'b1, 1'b0);
                    nmode = MODE_IDLE;
                end
                else if (text_byte == CHAR_NUL)
                begin
                    r[0]  = make_res(KIND_STRING, CHAR_NUL, 1'b1, 1'b1);
                    nmode = MODE_IDLE;
                end
                else
                begin
                    r[0]  = make_res(KIND_STRING, text_byte, 1'b0, 1'b0);
                    nmode = MODE_STRING;
                end
            end
            MODE_NUMBER:
            begin
                if (digit || ((text_byte == CHAR_DOT) && !dot))
                begin
                    n     = 2'd1;
                    r[0]  = make_res(KIND_NUMBER, text_byte, 1'b0, 1'b0);
                    nmode = MODE_NUMBER;
                    ndot  = dot | (text_byte == CHAR_DOT);
                end
                else
                begin
                    n    = idle_n + 2'd1;
                    r[0] = make_res(KIND_NUMBER, CHAR_NUL, 1'b1, 1'b0);
                    r[1] = idle_r0;
                    r[2] = idle_r1;
                    ndot = digit ? 1'b0 : 1'b0;
                end
            end
            default:
            begin
                // Idle: the defaults above already hold.
            end
        endcase

        // End of text always leaves the lexer idle with no dot.
        if (text_byte == CHAR_NUL)
        begin
            nmode = MODE_IDLE;
            ndot  = 1'b0;
        end

        case (n)
            2'd1:    r[0].run_last = 1'b1;
            2'd2:    r[1].run_last = 1'b1;
            2'd3:    r[2].run_last = 1'b1;
            default: ;
        endcase
    end

    assign dec.count = n;
    assign dec.res   = r;
    assign dec.mode  = nmode;
    assign dec.dot   = ndot;

endmodule
`default_nettype wire

FILE: verif/script_token_lexer_tb.sv
`timescale 1ns / 1ps

import sltl_pkg::*;

// Scoreboard for the token lexer. It keeps its own copy of the lexer mode and
// of the dot flag, turns every accepted text byte into the result transactions
// that byte must cause, and checks the results in order as they leave the block.
class lex_scoreboard;

    logic [1:0] lex_state;
    logic       number_has_dot;
    sltl_res_t  expected_tokens[$];
    sltl_res_t  byte_results[$];
    int         errors;
    int         bytes_seen;
    int         results_seen;
    int         tokens_closed;
    int         open_strings_closed;

    function new();
        lex_state           = MODE_IDLE;
        number_has_dot      = 1'b0;
        errors              = 0;
        bytes_seen          = 0;
        results_seen        = 0;
        tokens_closed       = 0;
        open_strings_closed = 0;
    endfunction

    function bit letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function bit symbol(logic [7:0] c);
        case (c)
            "{", "}", "(", ")", "!", ";", "+", "=",
            ",", "-", "*", "&", "|", "#": return 1'b1;
            default:                     return 1'b0;
        endcase
    endfunction

    function void add(logic [2:0] kind, logic [7:0] value, logic last_of_token,
                      logic open_string);
        sltl_res_t r;
        r.kind         = kind;
        r.value        = value;
        r.token_end    = last_of_token;
        r.unterminated = open_string;
        r.run_last     = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    // A byte seen with no token open: it may open one, be a symbol, or be dropped.
    function void start_token(logic [7:0] c);
        if (c == CHAR_NUL) begin
            return;
        end
        if (letter(c)) begin
            lex_state = MODE_IDENT;
            add(KIND_IDENT, c, 1'b0, 1'b0);
        end
        else if (c == CHAR_QUOTE) begin
            lex_state = MODE_STRING;
        end
        else if (digit(c)) begin
            lex_state      = MODE_NUMBER;
            number_has_dot = 1'b0;
            add(KIND_NUMBER, c, 1'b0, 1'b0);
        end
        else if (symbol(c)) begin
            add(KIND_SYMBOL, c, 1'b0, 1'b0);
            add(KIND_SYMBOL, CHAR_NUL, 1'b1, 1'b0);
        end
    endfunction

    function void note_byte(logic [7:0] c);
        byte_results.delete();
        bytes_seen++;
        case (lex_state)
            MODE_IDENT: begin
                if (letter(c) || digit(c) || c == CHAR_DOT) begin
                    add(KIND_IDENT, c, 1'b0, 1'b0);
                end
                else begin
                    add(KIND_IDENT, CHAR_NUL, 1'b1, 1'b0);
                    lex_state = MODE_IDLE;
                    start_token(c);
                end
            end
            MODE_STRING: begin
                if (c == CHAR_QUOTE) begin
                    add(KIND_STRING, CHAR_NUL, 1'b1, 1'b0);
                    lex_state = MODE_IDLE;
                end
                else if (c == CHAR_NUL) begin
                    add(KIND_STRING, CHAR_NUL, 1'b1, 1'b1);
                    lex_state = MODE_IDLE;
                end
                else begin
                    add(KIND_STRING, c, 1'b0, 1'b0);
                end
            end
            MODE_NUMBER: begin
                if (digit(c) || (c == CHAR_DOT && !number_has_dot)) begin
                    if (c == CHAR_DOT) begin
                        number_has_dot = 1'b1;
                    end
                    add(KIND_NUMBER, c, 1'b0, 1'b0);
                end
                else begin
                    add(KIND_NUMBER, CHAR_NUL, 1'b1, 1'b0);
                    lex_state      = MODE_IDLE;
                    number_has_dot = 1'b0;
                    start_token(c);
                end
            end
            default: begin
                lex_state = MODE_IDLE;
                start_token(c);
            end
        endcase
        if (c == CHAR_NUL) begin
            lex_state      = MODE_IDLE;
            number_has_dot = 1'b0;
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].run_last = 1'b1;
        end
        foreach (byte_results[i]) begin
            expected_tokens.insert(expected_tokens.size(), byte_results[i]);
        end
    endfunction

    function void compare(string field, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_result(sltl_res_t act);
        sltl_res_t exp_res;
        if (expected_tokens.size() == 0) begin
            $display("%0t: result with nothing expected, actual kind %0h value %0h end %0b",
                     $time, act.kind, act.value, act.token_end);
            errors++;
            return;
        end
        exp_res = expected_tokens.pop_front();
        results_seen++;
        if (exp_res.token_end) begin
            tokens_closed++;
        end
        if (exp_res.unterminated) begin
            open_strings_closed++;
        end
        compare("token_kind", int'(exp_res.kind), int'(act.kind));
        compare("value_byte", int'(exp_res.value), int'(act.value));
        compare("token_end", int'(exp_res.token_end), int'(act.token_end));
        compare("unterminated", int'(exp_res.unterminated), int'(act.unterminated));
        compare("run_last", int'(exp_res.run_last), int'(act.run_last));
    endfunction

endclass

module script_token_lexer_tb;

    logic       clk;
    logic       rst_n;
    logic       text_valid;
    logic       text_ready;
    logic [7:0] text_byte;
    logic       token_valid;
    logic       token_ready;
    logic [2:0] token_kind;
    logic [7:0] value_byte;
    logic       token_end;
    logic       unterminated;
    logic       run_last;

    lex_scoreboard sb;

    // While this is set neither side inserts idle cycles, so the block is
    // exercised back to back for a stretch of the random traffic.
    bit         no_idle;
    int         random_bytes;
    string      symbol_chars;

    script_token_lexer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .value_byte   (value_byte),
        .token_end    (token_end),
        .unterminated (unterminated),
        .run_last     (run_last)
    );

    // 10 ns clock.
    initial begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every input has a known value from time zero.
    initial begin
        rst_n       = 1'b0;
        text_valid  = 1'b0;
        text_byte   = 8'h00;
        token_ready = 1'b0;
        no_idle     = 1'b0;
        sb          = new();
    end

    // Random back pressure on the result side. The ready is updated with a
    // nonblocking assignment at the clock edge, so the block sees it settle
    // before the next edge.
    always @(posedge clk)
    begin
        if (no_idle) begin
            token_ready <= 1'b1;
        end
        else begin
            token_ready <= ($urandom_range(0, 99) >= 38);
        end
    end

    // Monitor. It runs at the rising edge and reads the handshake signals
    // before any update of this edge lands, so an accepted transaction is
    // seen exactly as the block saw it. The input side and the result side
    // can both complete at the same edge; the result can never belong to the
    // byte accepted at that edge, because a byte passes through the input register
    // and then the result buffer before any of its results can leave the block.
    always @(posedge clk)
    begin
        sltl_res_t act;
        if (rst_n) begin
            if (text_valid && text_ready) begin
                sb.note_byte(text_byte);
            end
            if (token_valid && token_ready) begin
                act.kind         = token_kind;
                act.value        = value_byte;
                act.token_end    = token_end;
                act.unterminated = unterminated;
                act.run_last     = run_last;
                sb.check_result(act);
            end
        end
    end

    function bit take_gap();
        return !no_idle && ($urandom_range(0, 99) < 38);
    endfunction

    // Offers one text byte and returns at the edge where it was accepted.
    // The task is always entered at a rising edge, so a valid that stays
    // high from one transaction to the next is assigned only once per edge.
    task automatic send_byte(input logic [7:0] b);
        while (take_gap()) begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        @(posedge clk);
        while (!text_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    function logic [7:0] pick_letter();
        if ($urandom_range(0, 1)) begin
            return 8'("a" + $urandom_range(0, 25));
        end
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // One random token, mostly well formed so that every mode is reached
    // often; noise bytes, stray end-of-text bytes, doubled dots in numbers
    // and strings cut off by end of text make up the rest.
    task automatic send_random_token();
        int          roll;
        int          n;
        logic [7:0]  c;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            send_byte(pick_letter());
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 4))
                    0:       send_byte(pick_digit());
                    1:       send_byte(CHAR_DOT);
                    default: send_byte(pick_letter());
                endcase
            end
        end
        else if (roll < 45) begin
            send_byte(pick_digit());
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_byte(CHAR_DOT);
                end
                else begin
                    send_byte(pick_digit());
                end
            end
        end
        else if (roll < 65) begin
            send_byte(CHAR_QUOTE);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(1, 255));
                if (c == CHAR_QUOTE) begin
                    c = 8'h7F;
                end
                send_byte(c);
            end
            if ($urandom_range(0, 9) == 0) begin
                send_byte(CHAR_NUL);
            end
            else begin
                send_byte(CHAR_QUOTE);
            end
        end
        else if (roll < 80) begin
            send_byte(symbol_chars[$urandom_range(0, 13)]);
        end
        else if (roll < 92) begin
            case ($urandom_range(0, 2))
                0:       send_byte(" ");
                1:       send_byte(8'h0A);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        else begin
            send_byte(CHAR_NUL);
        end
    endtask

    initial begin
        symbol_chars = "{}()!;+=,-*&|#";

        // Reset is held low from time zero and released at a clock edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. End of text while idle, then an identifier over
        // letters, a digit and a dot that a symbol ends, which gives the
        // three-result case.
        send_byte(CHAR_NUL);
        send_text("aZ9.(");
        // A number with one dot; the second dot ends it and is then dropped.
        send_text("12.3.");
        // A string that carries the highest and the lowest non-ASCII bytes.
        send_byte(CHAR_QUOTE);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CHAR_QUOTE);
        // The empty string gives only its end marker.
        send_byte(CHAR_QUOTE);
        send_byte(CHAR_QUOTE);
        // A non-ASCII byte outside a string ends the number and is dropped.
        send_byte("7");
        send_byte(8'hFF);
        // A string still open at end of text is closed with the flag set.
        send_byte(CHAR_QUOTE);
        send_byte("x");
        send_byte(CHAR_NUL);
        // End of text also closes an open identifier.
        send_byte("q");
        send_byte(CHAR_NUL);

        // Random part, with a stretch in the middle where neither side idles.
        random_bytes = 0;
        while (random_bytes < 145) begin
            no_idle = (random_bytes >= 60) && (random_bytes < 110);
            send_random_token();
            random_bytes = sb.bytes_seen - 24;
        end
        no_idle = 1'b0;

        // Close whatever token is still open, then stop offering input.
        send_byte(CHAR_NUL);
        text_valid <= 1'b0;
        @(posedge clk);

        // Wait for every expected result, then a few more cycles in case
        // the block produces anything extra.
        while (sb.expected_tokens.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Lexed %0d text bytes into %0d result transactions.",
                 sb.bytes_seen, sb.results_seen);
        $display("Closed %0d tokens, %0d of them strings cut off by end of text.",
                 sb.tokens_closed, sb.open_strings_closed);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: the whole run needs far fewer cycles than this.
    initial begin
        #3000000;
        $display("Run did not finish in time, %0d results still expected.",
                 sb.expected_tokens.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
